/* hdl/cprs_pkg.sv */
// Shared types and constants for the crowded point removal select block.
// Used by cprs_dist and crowded_point_removal_select_top; depends on nothing.
`default_nettype none
package cprs_pkg;

  // Number of coordinate axes held per point.
  localparam int NUM_AXES = 3;

  // Axis and phase counter of the distance unit.
  typedef logic [1:0] axis_t;

  // Status that the distance unit reports to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } dist_stat_t;

endpackage
`default_nettype wire

/* hdl/cprs_dist.sv */
// Iterative squared-distance unit: one shared squarer, one axis per cycle.
// Depends on cprs_pkg.
`default_nettype none
module cprs_dist import cprs_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [NUM_AXES*COORD_BITS-1:0]    coord_a,
  input  wire logic [NUM_AXES*COORD_BITS-1:0]    coord_b,
  output logic      [2*COORD_BITS+1:0]           sq_dist,
  output dist_stat_t                             stat
);

  localparam int DB = 2 * COORD_BITS + 2;

  logic [NUM_AXES*COORD_BITS-1:0] a_q;
  logic [NUM_AXES*COORD_BITS-1:0] b_q;
  axis_t                          phase;
  logic [DB-1:0]                  prod;
  logic [DB-1:0]                  acc;
  logic                           busy;
  logic                           done;
  logic signed [COORD_BITS:0]     diff;
  logic [COORD_BITS-1:0]          mag;
  logic [2*COORD_BITS-1:0]        sq;

  // The difference of the selected axis, one bit wider than a coordinate.
  // Its magnitude always fits in COORD_BITS bits, so the squarer is
  // COORD_BITS by COORD_BITS and unsigned.
  always_comb begin
    diff = '0;
    case (phase)
      2'd0: diff = (COORD_BITS+1)'($signed(a_q[COORD_BITS-1:0]))
                 - (COORD_BITS+1)'($signed(b_q[COORD_BITS-1:0]));
      2'd1: diff = (COORD_BITS+1)'($signed(a_q[2*COORD_BITS-1:COORD_BITS]))
                 - (COORD_BITS+1)'($signed(b_q[2*COORD_BITS-1:COORD_BITS]));
      2'd2: diff = (COORD_BITS+1)'($signed(a_q[3*COORD_BITS-1:2*COORD_BITS]))
                 - (COORD_BITS+1)'($signed(b_q[3*COORD_BITS-1:2*COORD_BITS]));
      default: diff = '0;
    endcase
    mag = diff[COORD_BITS] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
    sq  = mag * mag;
  end

  // The square of one axis is registered, then added in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q   <= coord_a;
        b_q   <= coord_b;
        acc   <= '0;
        phase <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (phase != 2'd3) begin
          prod <= DB'(sq);
        end
        if (phase != 2'd0) begin
          acc <= acc + prod;
        end
        if (phase == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        phase <= phase + 2'd1;
      end
    end
  end

  assign sq_dist   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

/* hdl/crowded_point_removal_select_top.sv */
// Top level of the crowded point removal select block.
// Depends on cprs_pkg and instantiates cprs_dist.
`default_nettype none
// The block collects the points of one cell, one transfer per cycle, until a
// point with last_point set. If the cell holds no more than max_per_cell
// points, one result with none_removed set follows. Otherwise every point is
// scored by the sum of its two smallest squared distances to the other points
// (a missing neighbour counts as an all-ones distance), and the surplus
// points with the lowest scores, ties to the lower index, are reported in
// ascending order, each index reduced by the number reported before it.
// Points beyond MAX_POINTS are dropped, though their last flag still closes
// the set; the tag reported is the cell_id of the first point. Scoring n
// points walks every ordered pair through one shared distance unit that
// squares one axis per cycle; ranking then reads the score memory once per
// pair. Input is stalled from the last point until the final result of the
// set has been transferred. The max_per_cell register may be written at any
// time the block is idle.
module crowded_point_removal_select_top import cprs_pkg::*; #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] point_x,
  input  wire logic signed [15:0] point_y,
  input  wire logic signed [15:0] point_z,
  input  wire logic        [15:0] cell_id,
  input  wire logic               last_point,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic             [4:0]  removal_index,
  output logic             [15:0] cell_id_out,
  output logic                    none_removed,
  output logic                    last_result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [5:0]  cfg_data
);

  localparam int DB   = 2 * COORD_BITS + 2;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int IXW  = (COORD_BITS > 16) ? COORD_BITS : 16;
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int XW   = (CW > 5) ? CW : 5;
  localparam int PW   = NUM_AXES * COORD_BITS;

  typedef enum logic [3:0] {
    S_LOAD, S_DECIDE, S_IRD, S_ILAT, S_JRD, S_JST, S_JWAIT, S_WSC,
    S_RI, S_RIL, S_RJ, S_RJL, S_REM, S_RNEXT, S_OUT
  } state_t;

  state_t          state;
  logic [5:0]      max_per_cell;
  logic [CW-1:0]   point_count;
  logic [CW-1:0]   n_pts;
  logic [CW-1:0]   surplus;
  logic [CW-1:0]   idx_i;
  logic [CW-1:0]   idx_j;
  logic [CW-1:0]   rank;
  logic [CW-1:0]   emitted;
  logic [15:0]     held_cell_tag;
  logic [PW-1:0]   coord_i;
  logic [DB-1:0]   near0;
  logic [DB-1:0]   near1;
  logic [DB:0]     score_i;

  logic [PW-1:0]   coord_mem [MAX_POINTS];
  logic [DB:0]     score_mem [MAX_POINTS];
  logic [PW-1:0]   coord_rd;
  logic [DB:0]     score_rd;
  logic [IW-1:0]   coord_raddr;
  logic [IW-1:0]   score_raddr;

  logic            in_acc;
  logic            dist_start;
  logic [DB-1:0]   sq_dist;
  dist_stat_t      dstat;
  logic [IXW-1:0]  xw, yw, zw;
  logic [PW-1:0]   new_point;
  logic [CW-1:0]   count_next;
  logic [XW-1:0]   reduced;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_LOAD);
  assign out_valid = (state == S_OUT);
  assign in_acc    = in_valid && !in_stall;

  // Coordinates are taken from the low COORD_BITS bits of each field.
  assign xw        = IXW'($unsigned(point_x));
  assign yw        = IXW'($unsigned(point_y));
  assign zw        = IXW'($unsigned(point_z));
  assign new_point = {zw[COORD_BITS-1:0], yw[COORD_BITS-1:0], xw[COORD_BITS-1:0]};
  assign count_next = (point_count < CW'(MAX_POINTS)) ? point_count + 1'b1 : point_count;
  assign reduced    = XW'(idx_i) - XW'(emitted);

  always_comb begin
    coord_raddr = idx_j[IW-1:0];
    score_raddr = idx_j[IW-1:0];
    if (state == S_IRD) begin
      coord_raddr = idx_i[IW-1:0];
    end
    if (state == S_RI) begin
      score_raddr = idx_i[IW-1:0];
    end
  end

  assign dist_start = (state == S_JST);

  // Point and score memories, one write and one registered read each.
  always_ff @(posedge clk) begin
    if (in_acc && point_count < CW'(MAX_POINTS)) begin
      coord_mem[point_count[IW-1:0]] <= new_point;
    end
    coord_rd <= coord_mem[coord_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_WSC) begin
      score_mem[idx_i[IW-1:0]] <= (DB+1)'(near0) + (DB+1)'(near1);
    end
    score_rd <= score_mem[score_raddr];
  end

  cprs_dist #(
    .COORD_BITS(COORD_BITS)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .start   (dist_start),
    .coord_a (coord_i),
    .coord_b (coord_rd),
    .sq_dist (sq_dist),
    .stat    (dstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      max_per_cell  <= 6'd16;
      point_count   <= '0;
      held_cell_tag <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_per_cell <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (point_count == '0) begin
              held_cell_tag <= cell_id;
            end
            if (last_point) begin
              n_pts       <= count_next;
              point_count <= '0;
              state       <= S_DECIDE;
            end else begin
              point_count <= count_next;
            end
          end
        end
        S_DECIDE: begin
          if (CMPW'(n_pts) <= CMPW'(max_per_cell)) begin
            removal_index <= '0;
            cell_id_out   <= held_cell_tag;
            none_removed  <= 1'b1;
            last_result   <= 1'b1;
            state         <= S_OUT;
          end else begin
            surplus <= CW'(CMPW'(n_pts) - CMPW'(max_per_cell));
            idx_i   <= '0;
            state   <= S_IRD;
          end
        end
        S_IRD: begin
          state <= S_ILAT;
        end
        S_ILAT: begin
          coord_i <= coord_rd;
          idx_j   <= '0;
          near0   <= '1;
          near1   <= '1;
          state   <= S_JRD;
        end
        S_JRD: begin
          if (idx_j == n_pts) begin
            state <= S_WSC;
          end else if (idx_j == idx_i) begin
            idx_j <= idx_j + 1'b1;
          end else begin
            state <= S_JST;
          end
        end
        S_JST: begin
          state <= S_JWAIT;
        end
        S_JWAIT: begin
          if (dstat.done) begin
            // Keep the two smallest distances seen so far.
            if (sq_dist < near0) begin
              near1 <= near0;
              near0 <= sq_dist;
            end else if (sq_dist < near1) begin
              near1 <= sq_dist;
            end
            idx_j <= idx_j + 1'b1;
            state <= S_JRD;
          end
        end
        S_WSC: begin
          if (idx_i + 1'b1 == n_pts) begin
            idx_i   <= '0;
            emitted <= '0;
            state   <= S_RI;
          end else begin
            idx_i <= idx_i + 1'b1;
            state <= S_IRD;
          end
        end
        S_RI: begin
          state <= S_RIL;
        end
        S_RIL: begin
          score_i <= score_rd;
          idx_j   <= '0;
          rank    <= '0;
          state   <= S_RJ;
        end
        S_RJ: begin
          if (idx_j == n_pts) begin
            state <= S_REM;
          end else begin
            state <= S_RJL;
          end
        end
        S_RJL: begin
          if (score_rd < score_i || (score_rd == score_i && idx_j < idx_i)) begin
            rank <= rank + 1'b1;
          end
          idx_j <= idx_j + 1'b1;
          state <= S_RJ;
        end
        S_REM: begin
          if (rank < surplus) begin
            removal_index <= reduced[4:0];
            cell_id_out   <= held_cell_tag;
            none_removed  <= 1'b0;
            last_result   <= (emitted + 1'b1 == surplus);
            emitted       <= emitted + 1'b1;
            state         <= S_OUT;
          end else begin
            state <= S_RNEXT;
          end
        end
        S_RNEXT: begin
          idx_i <= idx_i + 1'b1;
          state <= S_RI;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= last_result ? S_LOAD : S_RNEXT;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Input and output never both move in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input accepted while a result is pending");

  // A none_removed result always closes its set.
  a_none_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_removed) |-> last_result)
    else $error("none_removed result without last_result");

  // The distance unit only finishes while the sequencer waits for it.
  a_dist_done: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_JWAIT))
    else $error("distance result arrived outside the wait state");

  // No more removals than the surplus are ever reported.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_REM) |-> (emitted < surplus))
    else $error("removal count exceeded the surplus");

endmodule
`default_nettype wire

/* sim/cprs_checker.sv */
// Checker for crowded_point_removal_select_top: watches the point, result and
// register channels, predicts the removal list of each cell and compares.
// Depends on nothing but the port widths of the block.
`timescale 1ns / 1ps
module cprs_checker #(
  parameter int MAX_POINTS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  input  logic signed [15:0] point_z,
  input  logic        [15:0] cell_id,
  input  logic               last_point,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic        [4:0]  removal_index,
  input  logic        [15:0] cell_id_out,
  input  logic               none_removed,
  input  logic               last_result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic        [5:0]  cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 removals_seen
);

  localparam longint unsigned NO_NEIGHBOR = (64'd1 << 34) - 1;

  typedef struct packed {
    logic [4:0]  idx;
    logic [15:0] tag;
    logic        none;
    logic        last;
  } removal_t;

  removal_t        removal_q[$];
  longint          pts[MAX_POINTS][3];
  longint unsigned score[MAX_POINTS];
  int              held_n;
  logic [15:0]     held_tag;
  logic [5:0]      keep_limit;

  function automatic longint unsigned sq_gap(int a, int b);
    longint unsigned s;
    longint d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = pts[a][k] - pts[b][k];
      s += longint'(d * d);
    end
    return s;
  endfunction

  // Score every held point, then queue the surplus in ascending index order, or one none_removed result.
  task automatic predict_removals();
    longint unsigned d0, d1, d;
    int surplus, rank, done;
    removal_t r;
    if (held_n <= keep_limit) begin
      r.idx = '0; r.tag = held_tag; r.none = 1'b1; r.last = 1'b1;
      removal_q = {removal_q, r};
      return;
    end
    surplus = held_n - keep_limit;
    for (int i = 0; i < held_n; i++) begin
      d0 = NO_NEIGHBOR;
      d1 = NO_NEIGHBOR;
      for (int j = 0; j < held_n; j++) begin
        if (j == i) continue;
        d = sq_gap(i, j);
        if (d < d0) begin
          d1 = d0;
          d0 = d;
        end else if (d < d1) begin
          d1 = d;
        end
      end
      score[i] = d0 + d1;
    end
    done = 0;
    for (int i = 0; i < held_n; i++) begin
      rank = 0;
      for (int j = 0; j < held_n; j++)
        if (score[j] < score[i] || (score[j] == score[i] && j < i)) rank++;
      if (rank < surplus) begin
        r.idx = 5'(i - done); r.tag = held_tag; r.none = 1'b0;
        r.last = (done + 1 == surplus);
        removal_q = {removal_q, r};
        done++;
      end
    end
  endtask

  always @(posedge clk) begin
    removal_t want, got;
    if (rst) begin
      held_n = 0;
      held_tag = '0;
      keep_limit = 6'd16;
      removal_q.delete();
      fail_count <= 0;
      removals_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) keep_limit = cfg_data;
      if (in_valid && !in_stall) begin
        if (held_n == 0) held_tag = cell_id;
        if (held_n < MAX_POINTS) begin
          pts[held_n][0] = point_x;
          pts[held_n][1] = point_y;
          pts[held_n][2] = point_z;
          held_n = held_n + 1;
        end
        if (last_point) begin
          predict_removals();
          held_n = 0;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{removal_index, cell_id_out, none_removed, last_result};
        if (!got.none) removals_seen <= removals_seen + 1;
        if (removal_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: idx %0d tag %h none %b last %b",
                     got.idx, got.tag, got.none, got.last);
          fail_count <= fail_count + 1;
        end else begin
          want = removal_q.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display("mismatch: expected idx %0d tag %h none %b last %b, got idx %0d tag %h none %b last %b",
                       want.idx, want.tag, want.none, want.last,
                       got.idx, got.tag, got.none, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= removal_q.size();
  end

endmodule

/* sim/tb_crowded_point_removal_select_top.sv */
// Testbench top for crowded_point_removal_select_top: drives cells of points
// and register writes, stalls results at random; depends on cprs_checker.
`timescale 1ns / 1ps
module tb_crowded_point_removal_select_top;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] point_x = '0, point_y = '0, point_z = '0;
  logic        [15:0] cell_id = '0;
  logic               last_point = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic        [4:0]  removal_index;
  logic        [15:0] cell_id_out;
  logic               none_removed, last_result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic        [5:0]  cfg_data = '0;

  int fail_count, pending, removals_seen;
  int points_sent = 0;
  int cells_sent = 0;
  int limits_used = 0;
  int quiet_cycles = 0;
  // The receiver looks at these flags before each transfer it waits for.
  bit long_hold = 1'b0;
  bit eager = 1'b0;

  always #1 clk = ~clk;

  crowded_point_removal_select_top DUT (
    .clk, .rst, .in_valid, .in_stall, .point_x, .point_y, .point_z,
    .cell_id, .last_point, .out_valid, .out_stall, .removal_index,
    .cell_id_out, .none_removed, .last_result, .cfg_valid, .cfg_ready,
    .cfg_data
  );

  cprs_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .point_x, .point_y, .point_z,
    .cell_id, .last_point, .out_valid, .out_stall, .removal_index,
    .cell_id_out, .none_removed, .last_result, .cfg_valid, .cfg_ready,
    .cfg_data, .fail_count, .pending, .removals_seen
  );

  // Watchdog: scoring a cell transfers nothing at all, so the quiet limit
  // must sit well above the scoring time of a full cell of 32 points.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 60000) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Each transfer is preceded by a random stall, none while
  // eager is set; when long_hold is raised the stall is stretched, which
  // backs the block up while the sender keeps offering points.
  initial begin
    int wait_cycles;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      wait_cycles = eager ? 0 : $urandom_range(0, 8);
      if (long_hold) begin
        wait_cycles = 400;
        long_hold = 1'b0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Offer one point. The caller is always at a rising edge, right after reset,
  // after a register write or at the edge of the previous transfer.
  task automatic send_point(input logic [15:0] x, y, z, tag, input logic fin);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    point_x <= x;
    point_y <= y;
    point_z <= z;
    cell_id <= tag;
    last_point <= fin;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    points_sent++;
  endtask

  // Wait for every expected result, then give the block time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  // The limit register is written only once the block is idle.
  task automatic set_limit(input logic [5:0] lim);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= lim;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    limits_used++;
  endtask

  // A cell of n points. Clustered cells use a narrow spread around a random
  // center, which makes near ties and exact duplicates common.
  task automatic send_cell(input int n, input bit clustered);
    logic [15:0] cx, cy, cz, tag;
    logic [15:0] px, py, pz;
    int spread;
    cx = 16'($urandom); cy = 16'($urandom); cz = 16'($urandom);
    tag = 16'($urandom);
    spread = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 64);
    for (int i = 0; i < n; i++) begin
      if (clustered) begin
        px = cx + 16'($urandom_range(0, spread));
        py = cy + 16'($urandom_range(0, spread));
        pz = ($urandom_range(0, 3) == 0) ? 16'd0 : cz + 16'($urandom_range(0, spread));
      end else begin
        px = 16'($urandom); py = 16'($urandom); pz = 16'($urandom);
      end
      // Later points carry their own tags; only the first one counts.
      send_point(px, py, pz, (i == 0) ? tag : 16'($urandom), i == n - 1);
    end
    cells_sent++;
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The reset limit of 16 keeps a three point cell whole.
    send_point(16'h7fff, 16'h8000, 16'h7fff, 16'hffff, 1'b0);
    send_point(16'h8000, 16'h7fff, 16'h8000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h1234, 1'b1);
    // A zero limit removes everything; a lone point only has missing
    // neighbors, and two equal points tie on their score.
    set_limit(6'd0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1);
    send_point(16'h0100, 16'h0100, 16'h0000, 16'haaaa, 1'b0);
    send_point(16'h0100, 16'h0100, 16'h0000, 16'h5555, 1'b1);
    send_point(16'h7fff, 16'h7fff, 16'h7fff, 16'hffff, 1'b0);
    send_point(16'h8000, 16'h8000, 16'h8000, 16'h0001, 1'b0);
    send_point(16'h7fff, 16'h8000, 16'h0000, 16'h0002, 1'b1);
    // One removal out of a square with one point pulled in.
    set_limit(6'd3);
    send_point(16'h0000, 16'h0000, 16'h0000, 16'h00c3, 1'b0);
    send_point(16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0000, 16'h0100, 16'h0000, 16'h0000, 1'b0);
    send_point(16'h0040, 16'h0040, 16'h0000, 16'h0000, 1'b1);
    // Largest limit; a two point cell is kept whole.
    set_limit(6'd32);
    send_cell(2, 1'b1);

    // Random part: phases under different limits, the extremes among them.
    while (points_sent < 330) begin
      case (limits_used % 6)
        0: set_limit(6'd0);
        1: set_limit(6'd1);
        2: set_limit(6'd32);
        3: set_limit(6'd31);
        default: set_limit(6'($urandom_range(0, 32)));
      endcase
      // Every fifth phase runs with no idling at all, another in five backs the block up.
      eager = (limits_used % 5 == 3);
      if (limits_used % 5 == 2) long_hold = 1'b1;
      for (int c = 0; c < 4; c++) begin
        n = $urandom_range(1, 8);
        // A cell that overflows the store drops its extra points.
        if (limits_used == 5 && c == 0) n = 34;
        else if ($urandom_range(0, 15) == 0) n = $urandom_range(9, 16);
        send_cell(n, $urandom_range(0, 2) != 0);
      end
      eager = 1'b0;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Sent %0d points in %0d cells under %0d limit settings;",
             points_sent, cells_sent, limits_used);
    $display("%0d removals reported by the block.", removals_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/cprs_pkg.sv
hdl/cprs_dist.sv
hdl/crowded_point_removal_select_top.sv
sim/cprs_checker.sv
sim/tb_crowded_point_removal_select_top.sv
